@@ rtl/bqd_pkg.sv @@
package bqd_pkg;

  // Defaults for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 28;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CUTOFF_HZ        = 2'd0,
    REG_SAMPLE_PERIOD_US = 2'd1,
    REG_ADAPTIVE         = 2'd2
  } cfg_reg_t;

  localparam int CUTOFF_W = 14;
  localparam int DT_W     = 20;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 14'd10;
  localparam logic [DT_W-1:0]     PERIOD_RESET = 20'd1000;

  // Fixed-point constants.
  localparam logic [22:0] OMEGA_Q40 = 23'd6908435;       // 2*pi*2^40/1e6
  localparam logic [31:0] SQRT8_Q30 = 32'd3037000500;    // 2*sqrt(2)*2^30

  // Alpha formats: raw product, coarse shift down to 29 fraction bits,
  // then one bit at a time until it fits in 31 bits.
  localparam int P_W            = CUTOFF_W + DT_W;       // 34
  localparam int A_RAW_W        = 57;
  localparam int ALPHA_MAX_FRAC = 29;
  localparam int PRE_SHIFT      = 40 - ALPHA_MAX_FRAC;   // 11
  localparam int NORM_W         = A_RAW_W - PRE_SHIFT;   // 46
  localparam int ALPHA_W        = 31;
  localparam int FRAC_W         = 5;

  // Wide unsigned words for the coefficient divisions.
  localparam int WIDE_W = 64;
  localparam int LANES  = 3;

  // Shared multiplier operand widths (signed).
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int Y_W   = 32;
  localparam int ACC_W = 56;

endpackage

@@ rtl/bqd_divider.sv @@
module bqd_divider #(
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [bqd_pkg::WIDE_W-1:0] den,
  input  logic [bqd_pkg::LANES-1:0][bqd_pkg::WIDE_W-1:0] num,
  output logic done,
  output logic [bqd_pkg::LANES-1:0][COEF_FRAC_BITS+1:0] quot
);

  localparam int STEPS = COEF_FRAC_BITS + 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam int W     = bqd_pkg::WIDE_W;

  logic             busy;
  logic             first;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     den_q;
  logic [bqd_pkg::LANES-1:0][W-1:0] rem;

  logic [W:0] shifted [bqd_pkg::LANES];
  logic [W:0] diff    [bqd_pkg::LANES];
  logic       fits    [bqd_pkg::LANES];

  // Restoring division, one quotient bit per cycle in every lane. The first
  // step takes the integer bit without shifting the remainder.
  always_comb begin
    for (int i = 0; i < bqd_pkg::LANES; i++) begin
      shifted[i] = first ? {1'b0, rem[i]} : {rem[i], 1'b0};
      diff[i]    = shifted[i] - {1'b0, den_q};
      fits[i]    = shifted[i] >= {1'b0, den_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      first <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        cnt   <= '0;
        den_q <= den;
        rem   <= num;
        quot  <= '0;
      end else if (busy) begin
        first <= 1'b0;
        cnt   <= cnt + CNT_W'(1);
        for (int i = 0; i < bqd_pkg::LANES; i++) begin
          rem[i]  <= fits[i] ? diff[i][W-1:0] : shifted[i][W-1:0];
          quot[i] <= {quot[i][STEPS-2:0], fits[i]};
        end
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/butterworth_lowpass_biquad.sv @@
// Second-order Butterworth low-pass biquad, coefficients recomputed for every beat.
// The time from input beat to result depends on the alpha normalize loop and the
// coefficient divider. A new beat is taken only once the previous one has finished;
// one shared multiplier serves all.
// Reset (rst, synchronous, active high) restores the register defaults and
// clears the filter history; there is no clearing pass.
module butterworth_lowpass_biquad #(
  parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bqd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bqd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  logic [bqd_pkg::DT_W-1:0]            elapsed_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      filtered
);

  localparam int COEF_W  = COEF_FRAC_BITS + 3;
  localparam int Q_W     = COEF_FRAC_BITS + 2;
  localparam int PROD_W  = bqd_pkg::PROD_W;
  localparam int ACC_W   = bqd_pkg::ACC_W;
  localparam int Y_W     = bqd_pkg::Y_W;
  localparam int W       = bqd_pkg::WIDE_W;
  localparam int SHX     = COEF_FRAC_BITS - 16;
  localparam int OW      = 34;

  // Rounding offsets for half-up rounding of the product terms. The input
  // terms drop SHX bits, which may be none; the output terms drop
  // COEF_FRAC_BITS bits.
  localparam logic signed [PROD_W-1:0] RND_X = (PROD_W'(1) << SHX) >> 1;
  localparam logic signed [PROD_W-1:0] RND_Y = PROD_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
  localparam logic signed [OW-1:0]    O_HI  = OW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [OW-1:0]    O_LO  = -O_HI - OW'(1);
  localparam logic signed [OW-1:0]    O_RND = OW'(32768);

  typedef enum logic [16:0] {
    S_IDLE = 17'b00000000000000001,
    S_MP   = 17'b00000000000000010,
    S_MA   = 17'b00000000000000100,
    S_SH   = 17'b00000000000001000,
    S_NORM = 17'b00000000000010000,
    S_SQ   = 17'b00000000000100000,
    S_T    = 17'b00000000001000000,
    S_DEN  = 17'b00000000010000000,
    S_NUM  = 17'b00000000100000000,
    S_DIV  = 17'b00000001000000000,
    S_COEF = 17'b00000010000000000,
    S_M0   = 17'b00000100000000000,
    S_M1   = 17'b00001000000000000,
    S_M2   = 17'b00010000000000000,
    S_M3   = 17'b00100000000000000,
    S_M4   = 17'b01000000000000000,
    S_M5   = 17'b10000000000000000
  } state_t;

  // Configuration registers.
  logic [bqd_pkg::CUTOFF_W-1:0] cutoff_hz;
  logic [bqd_pkg::DT_W-1:0]     sample_period_us;
  logic                         adaptive;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_hz        <= bqd_pkg::CUTOFF_RESET;
      sample_period_us <= bqd_pkg::PERIOD_RESET;
      adaptive         <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bqd_pkg::REG_CUTOFF_HZ:        cutoff_hz        <= cfg_data[bqd_pkg::CUTOFF_W-1:0];
        bqd_pkg::REG_SAMPLE_PERIOD_US: sample_period_us <= cfg_data[bqd_pkg::DT_W-1:0];
        bqd_pkg::REG_ADAPTIVE:         adaptive         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t state;
  logic   fin;   // the last accumulate is done and the result waits to be written

  // Item registers.
  logic signed [SAMPLE_WIDTH-1:0]  x_cur;
  logic [bqd_pkg::CUTOFF_W-1:0]    fz;
  logic [bqd_pkg::DT_W-1:0]        dt;

  // Alpha and the terms of the denominator.
  logic [bqd_pkg::NORM_W-1:0]      alpha;
  logic [bqd_pkg::FRAC_W-1:0]      frac;
  logic [W-1:0]                    s_sq;
  logic [W-1:0]                    t_lin;
  logic [W-1:0]                    four;
  logic [W-1:0]                    sfour;
  logic                            a0_neg;
  logic                            a1_neg;

  // Coefficients, signed Q3.COEF_FRAC_BITS.
  logic signed [COEF_W-1:0]        b0;
  logic signed [COEF_W-1:0]        b1;
  logic signed [COEF_W-1:0]        a0;
  logic signed [COEF_W-1:0]        a1;

  // History: inputs as integers, outputs in Q16.16.
  logic signed [SAMPLE_WIDTH-1:0]  x1;
  logic signed [SAMPLE_WIDTH-1:0]  x2;
  logic signed [Y_W-1:0]           y1;
  logic signed [Y_W-1:0]           y2;

  logic signed [ACC_W-1:0]         acc;

  // The one shared multiplier; its product is always registered.
  logic signed [bqd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bqd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]           mul_p;
  logic signed [PROD_W-1:0]           prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MP: begin
        mul_a = bqd_pkg::MUL_A_W'(fz);
        mul_b = bqd_pkg::MUL_B_W'(dt);
      end
      S_MA: begin
        mul_a = bqd_pkg::MUL_A_W'(prod[bqd_pkg::P_W-1:0]);
        mul_b = bqd_pkg::MUL_B_W'(bqd_pkg::OMEGA_Q40);
      end
      S_SQ: begin
        mul_a = bqd_pkg::MUL_A_W'(alpha[bqd_pkg::ALPHA_W-1:0]);
        mul_b = bqd_pkg::MUL_B_W'(alpha[bqd_pkg::ALPHA_W-1:0]);
      end
      S_T: begin
        mul_a = bqd_pkg::MUL_A_W'(alpha[bqd_pkg::ALPHA_W-1:0]);
        mul_b = bqd_pkg::MUL_B_W'(bqd_pkg::SQRT8_Q30);
      end
      S_M0: begin
        mul_a = bqd_pkg::MUL_A_W'(b0);
        mul_b = bqd_pkg::MUL_B_W'(x_cur);
      end
      S_M1: begin
        mul_a = bqd_pkg::MUL_A_W'(b1);
        mul_b = bqd_pkg::MUL_B_W'(x1);
      end
      S_M2: begin
        mul_a = bqd_pkg::MUL_A_W'(b0);
        mul_b = bqd_pkg::MUL_B_W'(x2);
      end
      S_M3: begin
        mul_a = bqd_pkg::MUL_A_W'(a0);
        mul_b = bqd_pkg::MUL_B_W'(y1);
      end
      S_M4: begin
        mul_a = bqd_pkg::MUL_A_W'(a1);
        mul_b = bqd_pkg::MUL_B_W'(y2);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Numerators and denominator of the three ratios. b0 = s/D,
  // a0 = (2*four - 2*s)/D and a1 = (t - (s + four))/D, each as a magnitude
  // and a sign.
  logic [W-1:0] den_w;
  logic [W-1:0] two_four;
  logic [W-1:0] two_s;
  logic         a0_neg_w;
  logic         a1_neg_w;
  logic [bqd_pkg::LANES-1:0][W-1:0] num_w;

  always_comb begin
    den_w    = sfour + t_lin;
    two_four = four << 1;
    two_s    = s_sq << 1;
    a0_neg_w = two_four < two_s;
    a1_neg_w = t_lin < sfour;
    num_w[0] = s_sq;
    num_w[1] = a0_neg_w ? two_s - two_four : two_four - two_s;
    num_w[2] = a1_neg_w ? sfour - t_lin : t_lin - sfour;
  end

  logic div_done;
  logic [bqd_pkg::LANES-1:0][Q_W-1:0] quot;

  bqd_divider #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_NUM),
    .den  (den_w),
    .num  (num_w),
    .done (div_done),
    .quot (quot)
  );

  // The divider leaves COEF_FRAC_BITS + 1 fraction bits; round half away from
  // zero to COEF_FRAC_BITS and apply the sign.
  function automatic logic signed [COEF_W-1:0] round_coef(input logic [Q_W-1:0] q,
                                                          input logic neg);
    logic [COEF_W-1:0]        qp1;
    logic signed [COEF_W-1:0] mag;
    qp1 = {1'b0, q} + COEF_W'(1);
    mag = signed'({1'b0, qp1[COEF_W-1:1]});
    return neg ? -mag : mag;
  endfunction

  // Each product term is rounded half up to Q16.16 before it is summed.
  logic signed [ACC_W-1:0] term_x;
  logic signed [ACC_W-1:0] term_y;
  logic signed [Y_W-1:0]   y_sat;
  logic signed [OW-1:0]    o_full;
  logic signed [SAMPLE_WIDTH-1:0] o_sat;

  always_comb begin
    term_x = ACC_W'((prod + RND_X) >>> SHX);
    term_y = ACC_W'((prod + RND_Y) >>> COEF_FRAC_BITS);

    if (acc > Y_MAX) begin
      y_sat = Y_W'(Y_MAX);
    end else if (acc < Y_MIN) begin
      y_sat = Y_W'(Y_MIN);
    end else begin
      y_sat = acc[Y_W-1:0];
    end

    o_full = (OW'(y_sat) + O_RND) >>> 16;
    if (o_full > O_HI) begin
      o_sat = O_HI[SAMPLE_WIDTH-1:0];
    end else if (o_full < O_LO) begin
      o_sat = O_LO[SAMPLE_WIDTH-1:0];
    end else begin
      o_sat = o_full[SAMPLE_WIDTH-1:0];
    end
  end

  // An input beat is taken when the sequencer is idle and no finished result waits;
  // the output register lets a finished result wait while the next item runs.
  assign in_ready = (state == S_IDLE) && !fin;

  always_ff @(posedge clk) begin
    prod <= mul_p;

    if (rst) begin
      state     <= S_IDLE;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
    end else begin
      // The finished result is committed once the output register is free;
      // otherwise an accepted result simply empties the register.
      if (fin && (!out_valid || out_ready)) begin
        filtered  <= o_sat;
        out_valid <= 1'b1;
        fin       <= 1'b0;
        x2        <= x1;
        x1        <= x_cur;
        y2        <= y1;
        y1        <= y_sat;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            x_cur <= sample;
            // A zero cutoff or a zero period is taken as one.
            fz    <= (cutoff_hz == '0) ? bqd_pkg::CUTOFF_W'(1) : cutoff_hz;
            if (adaptive) begin
              dt <= (elapsed_us == '0) ? bqd_pkg::DT_W'(1) : elapsed_us;
            end else begin
              dt <= (sample_period_us == '0) ? bqd_pkg::DT_W'(1) : sample_period_us;
            end
            state <= S_MP;
          end
        end
        S_MP: state <= S_MA;
        S_MA: state <= S_SH;
        S_SH: begin
          // Coarse shift from Q40 down to the largest allowed fraction.
          alpha <= prod[bqd_pkg::A_RAW_W-1:bqd_pkg::PRE_SHIFT];
          frac  <= bqd_pkg::FRAC_W'(bqd_pkg::ALPHA_MAX_FRAC);
          state <= S_NORM;
        end
        S_NORM: begin
          if (|alpha[bqd_pkg::NORM_W-1:bqd_pkg::ALPHA_W]) begin
            alpha <= alpha >> 1;
            frac  <= frac - bqd_pkg::FRAC_W'(1);
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_T;
        S_T: begin
          s_sq  <= W'(prod[2*bqd_pkg::ALPHA_W-1:0]);
          state <= S_DEN;
        end
        S_DEN: begin
          t_lin <= W'(prod[62:30]) << frac;
          four  <= W'(1) << ({1'b0, frac, 1'b0} + 7'd2);
          sfour <= s_sq + (W'(1) << ({1'b0, frac, 1'b0} + 7'd2));
          state <= S_NUM;
        end
        S_NUM: begin
          a0_neg <= a0_neg_w;
          a1_neg <= a1_neg_w;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_COEF;
          end
        end
        S_COEF: begin
          b0    <= round_coef(quot[0], 1'b0);
          b1    <= round_coef(quot[0], 1'b0) <<< 1;
          a0    <= round_coef(quot[1], a0_neg);
          a1    <= round_coef(quot[2], a1_neg);
          state <= S_M0;
        end
        S_M0: begin
          acc   <= '0;
          state <= S_M1;
        end
        S_M1: begin
          acc   <= acc + term_x;
          state <= S_M2;
        end
        S_M2: begin
          acc   <= acc + term_x;
          state <= S_M3;
        end
        S_M3: begin
          acc   <= acc + term_x;
          state <= S_M4;
        end
        S_M4: begin
          acc   <= acc + term_y;
          state <= S_M5;
        end
        S_M5: begin
          acc   <= acc + term_y;
          fin   <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
